>>> rtl/keypad_card_lock_controller_core_defines.svh
// assertion macros shared by the checker
`ifndef KEYPAD_CARD_LOCK_CONTROLLER_CORE_DEFINES_SVH
`define KEYPAD_CARD_LOCK_CONTROLLER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KCLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kclc check failed");

// antecedent implies consequent in the next cycle
`define KCLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kclc check failed");

`endif

>>> rtl/kclc_pkg.sv
`default_nettype none

package kclc_pkg;

    // key codes with a special meaning
    localparam logic [3:0] KEY_ONE  = 4'd1;
    localparam logic [3:0] KEY_TWO  = 4'd2;
    localparam logic [3:0] KEY_NINE = 4'd9;
    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_B    = 4'd11;
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_HASH = 4'd15;

    // request kinds
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_CARD = 1'b1;

    // mode codes as shown on the result
    localparam logic [2:0] MODE_SELECT_CODE  = 3'd0;
    localparam logic [2:0] MODE_CARD_CODE    = 3'd1;
    localparam logic [2:0] MODE_PIN_CODE     = 3'd2;
    localparam logic [2:0] MODE_CONFIRM_CODE = 3'd3;
    localparam logic [2:0] MODE_NEWPIN_CODE  = 3'd4;

    // operating mode, one-hot
    typedef enum logic [4:0] {
        M_SELECT  = 5'b00001,
        M_CARD    = 5'b00010,
        M_PIN     = 5'b00100,
        M_CONFIRM = 5'b01000,
        M_NEWPIN  = 5'b10000
    } mode_t;

    // event codes
    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_UNLOCK  = 4'd1,
        EV_DENY    = 4'd2,
        EV_LOCK    = 4'd3,
        EV_REG     = 4'd4,
        EV_UPDATED = 4'd5,
        EV_SAME    = 4'd6,
        EV_CANCEL  = 4'd7,
        EV_MODE    = 4'd8,
        EV_DIGIT   = 4'd9,
        EV_CLEARED = 4'd10
    } event_t;

    // request beat
    typedef struct packed {
        logic        req_type;
        logic [3:0]  key_code;
        logic        card_found;
        logic [31:0] card_uid;
    } req_t;

    // result beat
    typedef struct packed {
        logic       lock_released;
        logic [2:0] mode_now;
        logic [3:0] event_code;
        logic [2:0] digits_entered;
    } res_t;

    // mode to its external code
    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            M_SELECT:  c = MODE_SELECT_CODE;
            M_CARD:    c = MODE_CARD_CODE;
            M_PIN:     c = MODE_PIN_CODE;
            M_CONFIRM: c = MODE_CONFIRM_CODE;
            M_NEWPIN:  c = MODE_NEWPIN_CODE;
            default:   c = MODE_SELECT_CODE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kclc_req_if.sv
`default_nettype none

interface kclc_req_if;
    logic             valid;
    logic             ready;
    kclc_pkg::req_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/kclc_res_if.sv
`default_nettype none

interface kclc_res_if;
    logic             valid;
    logic             ready;
    kclc_pkg::res_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/kclc_engine.sv
`default_nettype none

module kclc_engine #(
    parameter int PIN_DIGITS = 4,
    parameter int UID_BYTES  = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire kclc_pkg::req_t item,
    output kclc_pkg::res_t      result
);

    localparam int CW = $clog2(PIN_DIGITS + 1);
    localparam int IW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam int UW = 8 * UID_BYTES;
    localparam logic [CW-1:0] FULL = CW'(PIN_DIGITS);

    kclc_pkg::mode_t  mode_reg, mode_next;
    logic             door_reg, door_next;
    logic [3:0]       entry_reg [PIN_DIGITS];
    logic [3:0]       entry_next [PIN_DIGITS];
    logic [CW-1:0]    count_reg, count_next;
    logic [3:0]       pin_reg [PIN_DIGITS];
    logic [3:0]       pin_next [PIN_DIGITS];
    logic [3:0]       newpin_reg [PIN_DIGITS];
    logic [3:0]       newpin_next [PIN_DIGITS];
    logic [CW-1:0]    newcnt_reg, newcnt_next;
    logic [UW-1:0]    uid_reg, uid_next;
    logic             uid_valid_reg, uid_valid_next;
    logic             seen_reg, seen_next;

    kclc_pkg::event_t ev;
    logic             clr;
    logic             entry_match;
    logic             newpin_match;
    logic [CW-1:0]    newcnt_inc;
    logic [CW-1:0]    cnt_sel;
    logic [3:0]       key;
    logic [UW-1:0]    uid_in;

    assign key    = item.key_code;
    assign uid_in = UW'(item.card_uid);

    // pin compare against the stored pin, entry and the new pin after this digit
    always_comb
    begin
        entry_match  = 1'b1;
        newpin_match = 1'b1;
        for (int i = 0; i < PIN_DIGITS; i++)
        begin
            if (entry_reg[i] != pin_reg[i])
                entry_match = 1'b0;
            if (newpin_next[i] != pin_reg[i])
                newpin_match = 1'b0;
        end
    end

    // new pin digit capture
    always_comb
    begin
        for (int i = 0; i < PIN_DIGITS; i++)
            newpin_next[i] = newpin_reg[i];
        newcnt_inc = newcnt_reg;
        if (mode_reg == kclc_pkg::M_NEWPIN && item.req_type == kclc_pkg::REQ_KEY &&
            key <= kclc_pkg::KEY_NINE && newcnt_reg < FULL)
        begin
            newpin_next[newcnt_reg[IW-1:0]] = key;
            newcnt_inc = newcnt_reg + CW'(1);
        end
    end

    // mode and event logic
    always_comb
    begin
        mode_next      = mode_reg;
        door_next      = door_reg;
        count_next     = count_reg;
        newcnt_next    = newcnt_reg;
        uid_next       = uid_reg;
        uid_valid_next = uid_valid_reg;
        seen_next      = seen_reg;
        ev             = kclc_pkg::EV_NONE;
        clr            = 1'b0;
        for (int i = 0; i < PIN_DIGITS; i++)
        begin
            entry_next[i] = entry_reg[i];
            pin_next[i]   = pin_reg[i];
        end

        if (item.req_type == kclc_pkg::REQ_KEY)
        begin
            case (mode_reg)
                kclc_pkg::M_SELECT:
                begin
                    if (key == kclc_pkg::KEY_ONE)
                    begin
                        mode_next = kclc_pkg::M_CARD;
                        ev        = kclc_pkg::EV_MODE;
                    end
                    else if (key == kclc_pkg::KEY_TWO)
                    begin
                        mode_next = kclc_pkg::M_PIN;
                        clr       = 1'b1;
                        ev        = kclc_pkg::EV_MODE;
                    end
                end
                kclc_pkg::M_CARD:
                begin
                    if (door_reg)
                    begin
                        if (key == kclc_pkg::KEY_HASH)
                        begin
                            door_next = 1'b0;
                            ev        = kclc_pkg::EV_LOCK;
                        end
                    end
                    else if (key == kclc_pkg::KEY_B)
                    begin
                        mode_next = kclc_pkg::M_SELECT;
                        clr       = 1'b1;
                        ev        = kclc_pkg::EV_MODE;
                    end
                end
                kclc_pkg::M_PIN:
                begin
                    if (door_reg)
                    begin
                        if (key == kclc_pkg::KEY_HASH)
                        begin
                            door_next = 1'b0;
                            clr       = 1'b1;
                            ev        = kclc_pkg::EV_LOCK;
                        end
                    end
                    else if (key == kclc_pkg::KEY_C)
                    begin
                        clr = 1'b1;
                        ev  = kclc_pkg::EV_CLEARED;
                    end
                    else if (key <= kclc_pkg::KEY_NINE)
                    begin
                        if (count_reg < FULL)
                        begin
                            entry_next[count_reg[IW-1:0]] = key;
                            count_next = count_reg + CW'(1);
                            ev         = kclc_pkg::EV_DIGIT;
                        end
                    end
                    else if (key == kclc_pkg::KEY_D)
                    begin
                        if (count_reg == FULL)
                        begin
                            clr = 1'b1;
                            if (entry_match)
                            begin
                                door_next = 1'b1;
                                ev        = kclc_pkg::EV_UNLOCK;
                            end
                            else
                                ev = kclc_pkg::EV_DENY;
                        end
                    end
                    else if (key == kclc_pkg::KEY_A)
                    begin
                        mode_next = kclc_pkg::M_CONFIRM;
                        clr       = 1'b1;
                        ev        = kclc_pkg::EV_MODE;
                    end
                    else if (key == kclc_pkg::KEY_B)
                    begin
                        mode_next = kclc_pkg::M_SELECT;
                        clr       = 1'b1;
                        ev        = kclc_pkg::EV_MODE;
                    end
                end
                kclc_pkg::M_CONFIRM:
                begin
                    if (key == kclc_pkg::KEY_A)
                    begin
                        mode_next   = kclc_pkg::M_NEWPIN;
                        newcnt_next = '0;
                        ev          = kclc_pkg::EV_MODE;
                    end
                    else if (key == kclc_pkg::KEY_B)
                    begin
                        mode_next = kclc_pkg::M_PIN;
                        clr       = 1'b1;
                        ev        = kclc_pkg::EV_CANCEL;
                    end
                end
                kclc_pkg::M_NEWPIN:
                begin
                    if (key <= kclc_pkg::KEY_NINE)
                    begin
                        if (newcnt_inc < FULL)
                        begin
                            newcnt_next = newcnt_inc;
                            ev          = kclc_pkg::EV_DIGIT;
                        end
                        else
                        begin
                            if (newpin_match)
                                ev = kclc_pkg::EV_SAME;
                            else
                            begin
                                for (int i = 0; i < PIN_DIGITS; i++)
                                    pin_next[i] = newpin_next[i];
                                ev = kclc_pkg::EV_UPDATED;
                            end
                            newcnt_next = '0;
                            mode_next   = kclc_pkg::M_PIN;
                            clr         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    ev = kclc_pkg::EV_NONE;
                end
            endcase
        end
        else if (mode_reg == kclc_pkg::M_CARD)
        begin
            // card poll: act only on a newly appearing card
            if (item.card_found && !seen_reg)
            begin
                if (!uid_valid_reg)
                begin
                    uid_next       = uid_in;
                    uid_valid_next = 1'b1;
                    ev             = kclc_pkg::EV_REG;
                end
                else if (uid_in == uid_reg)
                begin
                    door_next = 1'b1;
                    ev        = kclc_pkg::EV_UNLOCK;
                end
                else
                    ev = kclc_pkg::EV_DENY;
            end
            seen_next = item.card_found;
        end

        // clear the entry buffer
        if (clr)
        begin
            for (int i = 0; i < PIN_DIGITS; i++)
                entry_next[i] = 4'd0;
            count_next = '0;
        end
    end

    // digit count shown for the new mode
    always_comb
    begin
        case (mode_next)
            kclc_pkg::M_NEWPIN:  cnt_sel = newcnt_next;
            kclc_pkg::M_CONFIRM: cnt_sel = '0;
            default:             cnt_sel = count_next;
        endcase
    end

    assign result.lock_released  = door_next;
    assign result.mode_now       = kclc_pkg::mode_code(mode_next);
    assign result.event_code     = ev;
    assign result.digits_entered = 3'(cnt_sel);

    // lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= kclc_pkg::M_SELECT;
            door_reg      <= 1'b0;
            count_reg     <= '0;
            newcnt_reg    <= '0;
            uid_reg       <= '0;
            uid_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            for (int i = 0; i < PIN_DIGITS; i++)
            begin
                entry_reg[i] <= 4'd0;
                pin_reg[i]   <= 4'((i + 1) % 10);
            end
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            door_reg      <= door_next;
            count_reg     <= count_next;
            newcnt_reg    <= newcnt_next;
            uid_reg       <= uid_next;
            uid_valid_reg <= uid_valid_next;
            seen_reg      <= seen_next;
            for (int i = 0; i < PIN_DIGITS; i++)
            begin
                entry_reg[i] <= entry_next[i];
                pin_reg[i]   <= pin_next[i];
            end
        end
    end

    // new pin digits, written before they are read
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < PIN_DIGITS; i++)
                newpin_reg[i] <= newpin_next[i];
        end
    end

endmodule

`default_nettype wire

>>> rtl/keypad_card_lock_controller_core.sv
// path: request register, engine state update, result register
// throughput: one request per cycle unless res.ready holds the result
// register full; the engine updates state between the two registers
// reset: rst_n asynchronous active low; select mode, door locked, pin 1234,
// no card registered, both pipeline registers empty
`default_nettype none

module keypad_card_lock_controller_core #(
    parameter int PIN_DIGITS = 4,
    parameter int UID_BYTES  = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kclc_req_if.sink   req,
    kclc_res_if.source res
);

    logic           req_valid_reg;
    kclc_pkg::req_t req_data_reg;
    logic           res_valid_reg;
    kclc_pkg::res_t res_data_reg;
    kclc_pkg::res_t result;
    logic           advance;
    logic           step;

    // pipeline moves when the result register is free or being drained
    assign advance   = !res_valid_reg || res.ready;
    assign step      = req_valid_reg && advance;
    assign req.ready = !req_valid_reg || advance;
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (req.ready)
            req_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            req_data_reg <= req.data;
    end

    kclc_engine #(
        .PIN_DIGITS (PIN_DIGITS),
        .UID_BYTES  (UID_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (req_data_reg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_data_reg <= result;
    end

endmodule

`default_nettype wire

>>> rtl/kclc_checker.sv
`default_nettype none
`include "keypad_card_lock_controller_core_defines.svh"

module kclc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       lock_released,
    input wire logic [2:0] mode_now,
    input wire logic [3:0] event_code,
    input wire logic [2:0] digits_entered
);

    logic [10:0] beat;
    logic        open_mode;
    logic        is_unlock;
    logic        is_lock;
    logic        is_confirm;

    // whole result beat and the modes the fields are checked against
    assign beat       = {lock_released, mode_now, event_code, digits_entered};
    assign open_mode  = (mode_now == kclc_pkg::MODE_CARD_CODE) ||
                        (mode_now == kclc_pkg::MODE_PIN_CODE);
    assign is_unlock  = (event_code == kclc_pkg::EV_UNLOCK);
    assign is_lock    = (event_code == kclc_pkg::EV_LOCK);
    assign is_confirm = (mode_now == kclc_pkg::MODE_CONFIRM_CODE);

    // a stalled result beat holds
    `KCLC_ASSERT_NEXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(beat))

    // the door is only open in card or pin mode
    `KCLC_ASSERT_SAME(a_open_mode, clk, rst_n, out_valid && lock_released, open_mode)

    // unlock leaves the door open, lock leaves it shut
    `KCLC_ASSERT_SAME(a_unlock_open, clk, rst_n, out_valid && is_unlock, lock_released)
    `KCLC_ASSERT_SAME(a_lock_shut, clk, rst_n, out_valid && is_lock, !lock_released)

    // no digits shown while confirming a pin change
    `KCLC_ASSERT_SAME(a_confirm_empty, clk, rst_n, out_valid && is_confirm, digits_entered == 3'd0)

endmodule

bind keypad_card_lock_controller_core kclc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .lock_released  (res.data.lock_released),
    .mode_now       (res.data.mode_now),
    .event_code     (res.data.event_code),
    .digits_entered (res.data.digits_entered)
);

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIN_LEN     = 4;
    localparam int OPENING_LEN = 32;
    localparam int PHASE_BEATS = 530;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    // star has no meaning anywhere, so the package leaves it out
    localparam logic [3:0] KEY_STAR = 4'd14;

    // everything the lock remembers between key and card events
    typedef struct packed {
        logic [2:0]      mode;
        logic            door;
        logic [3:0][3:0] entry;
        logic [2:0]      entry_cnt;
        logic [3:0][3:0] pin;
        logic [3:0][3:0] fresh_pin;
        logic [2:0]      fresh_cnt;
        logic [31:0]     card_uid;
        logic            card_known;
        logic            card_held;
    } lock_state_t;

    localparam lock_state_t LOCK_AT_RESET = '{
        mode: kclc_pkg::MODE_SELECT_CODE, pin: 16'h4321, default: '0
    };

    // one opening request, with its result written out where it is obvious
    typedef struct packed {
        logic           typed;
        kclc_pkg::req_t req;
        kclc_pkg::res_t want;
    } step_row_t;

    logic clk;
    logic rst_n;

    kclc_req_if req_bus ();
    kclc_res_if res_bus ();

    keypad_card_lock_controller_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    lock_state_t    plan_st;
    lock_state_t    model_st;
    kclc_pkg::res_t due_results[$];
    int             errors;
    int             send_idle;
    int             recv_stall;
    int             quiet_cycles;

    step_row_t opening_steps [OPENING_LEN] = '{
        // select mode ignores keys and cards
        '{1'b1, '{kclc_pkg::REQ_KEY, 4'd5, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_SELECT_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd0, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, kclc_pkg::MODE_SELECT_CODE, kclc_pkg::EV_NONE, 3'd0}},
        // card mode: register, held card, absent card, wrong card, match
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_ONE, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_MODE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_REG, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b0, 32'h1234_5678},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b1, 32'h0},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_DENY, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b1, 32'hFFFF_FFFF},
            '{1'b1, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_UNLOCK, 3'd0}},
        // open door: only hash counts, a fresh matching card unlocks again
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_B, 1'b1, 32'hFFFF_FFFF},
            '{1'b1, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b0, 32'hFFFF_FFFF},
            '{1'b1, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_CARD, 4'd15, 1'b1, 32'hFFFF_FFFF},
            '{1'b1, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_UNLOCK, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_HASH, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_CARD_CODE, kclc_pkg::EV_LOCK, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_B, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_SELECT_CODE, kclc_pkg::EV_MODE, 3'd0}},
        // pin mode: partial D, clear, full entry, overflow digit, unlock
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_TWO, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_MODE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_D, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_NONE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_C, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_CLEARED, 3'd0}},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd1, 1'b0, 32'h0}, '0},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd2, 1'b0, 32'h0}, '0},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd3, 1'b0, 32'h0}, '0},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd4, 1'b0, 32'h0}, '0},
        '{1'b1, '{kclc_pkg::REQ_KEY, 4'd0, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_NONE, 3'd4}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_D, 1'b0, 32'h0},
            '{1'b1, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_UNLOCK, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_HASH, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_LOCK, 3'd0}},
        // pin change: cancel, then confirm and enter the same pin again
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_A, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_CONFIRM_CODE, kclc_pkg::EV_MODE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_B, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_PIN_CODE, kclc_pkg::EV_CANCEL, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_A, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_CONFIRM_CODE, kclc_pkg::EV_MODE, 3'd0}},
        '{1'b1, '{kclc_pkg::REQ_KEY, kclc_pkg::KEY_A, 1'b0, 32'h0},
            '{1'b0, kclc_pkg::MODE_NEWPIN_CODE, kclc_pkg::EV_MODE, 3'd0}},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd1, 1'b0, 32'h0}, '0},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd2, 1'b0, 32'h0}, '0},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd3, 1'b0, 32'h0}, '0},
        '{1'b0, '{kclc_pkg::REQ_KEY, 4'd4, 1'b0, 32'h0}, '0}
    };

    // next lock state and the result beat for one request
    function automatic kclc_pkg::res_t lock_step(inout lock_state_t s,
                                                 input kclc_pkg::req_t r);
        kclc_pkg::event_t ev;
        kclc_pkg::res_t   o;
        ev = kclc_pkg::EV_NONE;
        if (r.req_type == kclc_pkg::REQ_KEY)
        begin
            case (s.mode)
                kclc_pkg::MODE_SELECT_CODE:
                begin
                    if (r.key_code == kclc_pkg::KEY_ONE)
                    begin
                        s.mode = kclc_pkg::MODE_CARD_CODE;
                        ev = kclc_pkg::EV_MODE;
                    end
                    else if (r.key_code == kclc_pkg::KEY_TWO)
                    begin
                        s.mode = kclc_pkg::MODE_PIN_CODE;
                        s.entry = '0;
                        s.entry_cnt = '0;
                        ev = kclc_pkg::EV_MODE;
                    end
                end
                kclc_pkg::MODE_CARD_CODE:
                begin
                    if (s.door)
                    begin
                        if (r.key_code == kclc_pkg::KEY_HASH)
                        begin
                            s.door = 1'b0;
                            ev = kclc_pkg::EV_LOCK;
                        end
                    end
                    else if (r.key_code == kclc_pkg::KEY_B)
                    begin
                        s.mode = kclc_pkg::MODE_SELECT_CODE;
                        s.entry = '0;
                        s.entry_cnt = '0;
                        ev = kclc_pkg::EV_MODE;
                    end
                end
                kclc_pkg::MODE_PIN_CODE:
                begin
                    if (s.door)
                    begin
                        if (r.key_code == kclc_pkg::KEY_HASH)
                        begin
                            s.door = 1'b0;
                            s.entry = '0;
                            s.entry_cnt = '0;
                            ev = kclc_pkg::EV_LOCK;
                        end
                    end
                    else if (r.key_code == kclc_pkg::KEY_C)
                    begin
                        s.entry = '0;
                        s.entry_cnt = '0;
                        ev = kclc_pkg::EV_CLEARED;
                    end
                    else if (r.key_code <= kclc_pkg::KEY_NINE)
                    begin
                        if (s.entry_cnt < PIN_LEN)
                        begin
                            s.entry[s.entry_cnt] = r.key_code;
                            s.entry_cnt = s.entry_cnt + 3'd1;
                            ev = kclc_pkg::EV_DIGIT;
                        end
                    end
                    else if (r.key_code == kclc_pkg::KEY_D)
                    begin
                        if (s.entry_cnt == PIN_LEN)
                        begin
                            if (s.entry == s.pin)
                            begin
                                s.door = 1'b1;
                                ev = kclc_pkg::EV_UNLOCK;
                            end
                            else
                            begin
                                ev = kclc_pkg::EV_DENY;
                            end
                            s.entry = '0;
                            s.entry_cnt = '0;
                        end
                    end
                    else if (r.key_code == kclc_pkg::KEY_A || r.key_code == kclc_pkg::KEY_B)
                    begin
                        s.mode = (r.key_code == kclc_pkg::KEY_A) ?
                                 kclc_pkg::MODE_CONFIRM_CODE : kclc_pkg::MODE_SELECT_CODE;
                        s.entry = '0;
                        s.entry_cnt = '0;
                        ev = kclc_pkg::EV_MODE;
                    end
                end
                kclc_pkg::MODE_CONFIRM_CODE:
                begin
                    if (r.key_code == kclc_pkg::KEY_A)
                    begin
                        s.mode = kclc_pkg::MODE_NEWPIN_CODE;
                        s.fresh_cnt = '0;
                        ev = kclc_pkg::EV_MODE;
                    end
                    else if (r.key_code == kclc_pkg::KEY_B)
                    begin
                        s.mode = kclc_pkg::MODE_PIN_CODE;
                        s.entry = '0;
                        s.entry_cnt = '0;
                        ev = kclc_pkg::EV_CANCEL;
                    end
                end
                kclc_pkg::MODE_NEWPIN_CODE:
                begin
                    if (r.key_code <= kclc_pkg::KEY_NINE)
                    begin
                        s.fresh_pin[s.fresh_cnt] = r.key_code;
                        s.fresh_cnt = s.fresh_cnt + 3'd1;
                        ev = kclc_pkg::EV_DIGIT;
                        // last digit decides between a new pin and a repeat
                        if (s.fresh_cnt == PIN_LEN)
                        begin
                            if (s.fresh_pin == s.pin)
                            begin
                                ev = kclc_pkg::EV_SAME;
                            end
                            else
                            begin
                                s.pin = s.fresh_pin;
                                ev = kclc_pkg::EV_UPDATED;
                            end
                            s.fresh_cnt = '0;
                            s.mode = kclc_pkg::MODE_PIN_CODE;
                            s.entry = '0;
                            s.entry_cnt = '0;
                        end
                    end
                end
                default:
                begin
                    ev = kclc_pkg::EV_NONE;
                end
            endcase
        end
        else if (s.mode == kclc_pkg::MODE_CARD_CODE)
        begin
            // only a card that has just appeared is acted on
            if (r.card_found && !s.card_held)
            begin
                if (!s.card_known)
                begin
                    s.card_uid = r.card_uid;
                    s.card_known = 1'b1;
                    ev = kclc_pkg::EV_REG;
                end
                else if (r.card_uid == s.card_uid)
                begin
                    s.door = 1'b1;
                    ev = kclc_pkg::EV_UNLOCK;
                end
                else
                begin
                    ev = kclc_pkg::EV_DENY;
                end
            end
            s.card_held = r.card_found;
        end
        o.lock_released = s.door;
        o.mode_now = s.mode;
        o.event_code = ev;
        if (s.mode == kclc_pkg::MODE_NEWPIN_CODE)
            o.digits_entered = s.fresh_cnt;
        else if (s.mode == kclc_pkg::MODE_CONFIRM_CODE)
            o.digits_entered = 3'd0;
        else
            o.digits_entered = s.entry_cnt;
        return o;
    endfunction

    // mostly requests that make sense in the current mode, some noise
    function automatic kclc_pkg::req_t pick_request(input lock_state_t p);
        kclc_pkg::req_t r;
        int             roll;
        r.req_type = kclc_pkg::REQ_KEY;
        r.key_code = 4'($urandom_range(0, 15));
        r.card_found = 1'($urandom_range(0, 1));
        r.card_uid = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            r.req_type = 1'($urandom_range(0, 1));
            return r;
        end
        case (p.mode)
            kclc_pkg::MODE_SELECT_CODE:
            begin
                if (roll >= 25)
                    r.key_code = (roll < 62) ? kclc_pkg::KEY_ONE : kclc_pkg::KEY_TWO;
            end
            kclc_pkg::MODE_CARD_CODE:
            begin
                if (p.door && roll < 40)
                begin
                    r.key_code = kclc_pkg::KEY_HASH;
                end
                else if (!p.door && roll < 18)
                begin
                    r.key_code = kclc_pkg::KEY_B;
                end
                else
                begin
                    r.req_type = kclc_pkg::REQ_CARD;
                    if (p.card_known && $urandom_range(0, 1) == 1)
                        r.card_uid = p.card_uid;
                end
            end
            kclc_pkg::MODE_PIN_CODE:
            begin
                if (p.door)
                begin
                    if (roll < 50)
                        r.key_code = kclc_pkg::KEY_HASH;
                end
                else if (p.entry_cnt == PIN_LEN)
                begin
                    r.key_code = (roll < 80) ? kclc_pkg::KEY_D : kclc_pkg::KEY_C;
                end
                else if (roll < 18)
                begin
                    case ($urandom_range(0, 3))
                        0:       r.key_code = kclc_pkg::KEY_A;
                        1:       r.key_code = kclc_pkg::KEY_B;
                        2:       r.key_code = kclc_pkg::KEY_C;
                        default: r.key_code = KEY_STAR;
                    endcase
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    r.key_code = p.pin[p.entry_cnt];
                end
                else
                begin
                    r.key_code = 4'($urandom_range(0, 9));
                end
            end
            kclc_pkg::MODE_CONFIRM_CODE:
            begin
                r.key_code = (roll < 80) ? kclc_pkg::KEY_A : kclc_pkg::KEY_B;
            end
            kclc_pkg::MODE_NEWPIN_CODE:
            begin
                if (roll >= 20)
                begin
                    if ($urandom_range(0, 3) == 0)
                        r.key_code = p.pin[p.fresh_cnt];
                    else
                        r.key_code = 4'($urandom_range(0, 9));
                end
            end
            default:
            begin
                r.key_code = kclc_pkg::KEY_TWO;
            end
        endcase
        return r;
    endfunction

    // offer one request beat, predict its result once it is taken
    task automatic send_request(input step_row_t row);
        kclc_pkg::res_t got;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data <= row.req;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        got = lock_step(model_st, row.req);
        due_results.push_back(row.typed ? row.want : got);
    endtask

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: random back-pressure and field checks
    always @(posedge clk)
    begin
        kclc_pkg::res_t want;
        if (rst_n)
        begin
            res_bus.ready <= ($urandom_range(0, 99) >= recv_stall);
            if (res_bus.valid && res_bus.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding: %p", res_bus.data);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res_bus.data.lock_released !== want.lock_released)
                    begin
                        $error("lock_released: expected %0d, got %0d",
                               want.lock_released, res_bus.data.lock_released);
                        errors++;
                    end
                    if (res_bus.data.mode_now !== want.mode_now)
                    begin
                        $error("mode_now: expected %0d, got %0d",
                               want.mode_now, res_bus.data.mode_now);
                        errors++;
                    end
                    if (res_bus.data.event_code !== want.event_code)
                    begin
                        $error("event_code: expected %0d, got %0d",
                               want.event_code, res_bus.data.event_code);
                        errors++;
                    end
                    if (res_bus.data.digits_entered !== want.digits_entered)
                    begin
                        $error("digits_entered: expected %0d, got %0d",
                               want.digits_entered, res_bus.data.digits_entered);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** keypad_card_lock_controller_core: FAILED **");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        kclc_pkg::req_t r;
        int             n;
        int             phase;
        int             counted;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        res_bus.ready = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        plan_st = LOCK_AT_RESET;
        model_st = LOCK_AT_RESET;
        send_idle = 18;
        recv_stall = 75;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening
        for (n = 0; n < OPENING_LEN; n++)
        begin
            void'(lock_step(plan_st, opening_steps[n].req));
            send_request(opening_steps[n]);
        end

        // random traffic under three idling patterns
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 18 : (phase == 1) ? 75 : 0;
            recv_stall = (phase == 0) ? 75 : (phase == 1) ? 18 : 0;
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                r = pick_request(plan_st);
                void'(lock_step(plan_st, r));
                counted++;
                send_request('{1'b0, r, '0});
            end
        end
        req_bus.valid <= 1'b0;

        // drain, then wait for anything unexpected
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("** keypad_card_lock_controller_core: PASSED **");
        else
            $display("** keypad_card_lock_controller_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/kclc_pkg.sv
rtl/kclc_req_if.sv
rtl/kclc_res_if.sv
rtl/kclc_engine.sv
rtl/keypad_card_lock_controller_core.sv
rtl/kclc_checker.sv
dv/tb_top.sv
